@@ rtl/core/lit_pkg.sv @@
// types and constants shared by the line indent tokenizer files
`default_nettype none
package lit_pkg;

	localparam int ByteW  = 8;
	localparam int CountW = 9;

	localparam logic [1:0] MODE_INDENT = 2'd0;
	localparam logic [1:0] MODE_TOKEN  = 2'd1;
	localparam logic [1:0] MODE_SKIP   = 2'd2;

	localparam logic [1:0] ROLE_INDENT   = 2'd0;
	localparam logic [1:0] ROLE_TOKEN    = 2'd1;
	localparam logic [1:0] ROLE_SEP      = 2'd2;
	localparam logic [1:0] ROLE_LINE_END = 2'd3;

	localparam logic [2:0] STATUS_OK          = 3'd0;
	localparam logic [2:0] STATUS_CONTROL     = 3'd1;
	localparam logic [2:0] STATUS_INDENT_LONG = 3'd2;
	localparam logic [2:0] STATUS_TOKEN_LONG  = 3'd3;
	localparam logic [2:0] STATUS_TOO_MANY    = 3'd4;

	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;

	localparam logic [7:0] LIMIT_RESET = 8'd100;

	localparam logic CFG_MAX_LENGTH = 1'b0;
	localparam logic CFG_MAX_COUNT  = 1'b1;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CountW-1:0] indent_count;
		logic [CountW-1:0] token_length;
		logic [CountW-1:0] token_total;
	} lit_state_t;

	typedef struct packed {
		logic [ByteW-1:0]  echo_byte;
		logic [1:0]        byte_role;
		logic [ByteW-1:0]  token_number;
		logic [ByteW-1:0]  char_position;
		logic              token_first;
		logic              line_done;
		logic [2:0]        line_status;
		logic [CountW-1:0] tokens_in_line;
		logic [CountW-1:0] indent_length;
	} lit_result_t;

endpackage
`default_nettype wire

@@ rtl/core/lit_step.sv @@
// per-byte classification, counting and next line state
`default_nettype none
module lit_step (
	input  var lit_pkg::lit_state_t  state,
	input  var logic [7:0]           data_byte,
	input  var logic                 end_of_input,
	input  var logic [7:0]           max_token_length,
	input  var logic [7:0]           count_limit,
	output lit_pkg::lit_state_t      state_next,
	output lit_pkg::lit_result_t     result
);
	import lit_pkg::*;

	logic [CountW-1:0] ic_inc;
	logic [CountW-1:0] tt_inc;
	logic [CountW-1:0] tl_base;
	logic [CountW-1:0] tl_inc;
	logic [CountW-1:0] max_len;
	logic [CountW-1:0] max_cnt;
	logic              line_end;
	logic              is_blank;
	logic              is_control;

	always_comb begin
		max_len    = {1'b0, max_token_length};
		max_cnt    = {1'b0, count_limit};
		ic_inc     = state.indent_count + CountW'(1);
		tt_inc     = state.token_total + CountW'(1);
		tl_base    = (state.mode == MODE_TOKEN) ? state.token_length : '0;
		tl_inc     = tl_base + CountW'(1);
		line_end   = end_of_input || (data_byte inside {CHAR_LF, CHAR_CR});
		is_blank   = data_byte inside {CHAR_TAB, CHAR_SPACE};
		is_control = data_byte < CHAR_SPACE;

		result = '0;
		result.echo_byte = end_of_input ? '0 : data_byte;
		state_next = state;

		if (line_end) begin
			result.byte_role      = ROLE_LINE_END;
			result.line_done      = 1'b1;
			result.indent_length  = state.indent_count;
			result.tokens_in_line = state.token_total;
			if (state.mode == MODE_TOKEN && state.token_length != '0) begin
				result.tokens_in_line = tt_inc;
				if (tt_inc > max_cnt)
					result.line_status = STATUS_TOO_MANY;
			end
			state_next = '0;
		end else if (is_control && !is_blank) begin
			result.byte_role      = ROLE_LINE_END;
			result.line_done      = 1'b1;
			result.line_status    = STATUS_CONTROL;
			result.indent_length  = state.indent_count;
			result.tokens_in_line = state.token_total;
			state_next = '0;
		end else if (is_blank) begin
			case (state.mode)
				MODE_INDENT: begin
					result.byte_role     = ROLE_INDENT;
					result.char_position = state.indent_count[ByteW-1:0];
					state_next.indent_count = ic_inc;
					if (ic_inc > max_len) begin
						result.line_done      = 1'b1;
						result.line_status    = STATUS_INDENT_LONG;
						result.indent_length  = ic_inc;
						result.tokens_in_line = state.token_total;
						state_next = '0;
					end
				end
				MODE_TOKEN: begin
					result.byte_role        = ROLE_SEP;
					state_next.mode         = MODE_SKIP;
					state_next.token_length = '0;
					state_next.token_total  = tt_inc;
					if (tt_inc > max_cnt) begin
						result.line_done      = 1'b1;
						result.line_status    = STATUS_TOO_MANY;
						result.indent_length  = state.indent_count;
						result.tokens_in_line = tt_inc;
						state_next = '0;
					end
				end
				default: begin
					result.byte_role = ROLE_SEP;
				end
			endcase
		end else begin
			result.byte_role     = ROLE_TOKEN;
			result.token_first   = (state.mode != MODE_TOKEN);
			result.token_number  = state.token_total[ByteW-1:0];
			result.char_position = tl_base[ByteW-1:0];
			state_next.mode         = MODE_TOKEN;
			state_next.token_length = tl_inc;
			if (tl_inc > max_len) begin
				result.line_done      = 1'b1;
				result.line_status    = STATUS_TOKEN_LONG;
				result.indent_length  = state.indent_count;
				result.tokens_in_line = state.token_total;
				state_next = '0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/line_indent_tokenizer_top.sv @@
// top level of the line indent tokenizer
`default_nettype none
// Takes one text byte per item and returns one result item per byte, giving
// its role (indent blank, token char, separator blank, line end), token index,
// position, and at a line end or abort the status, token count and indent
// length. It takes one item per cycle unless m_tready stalls. The line state
// (mode and the three counters) is updated as an item moves from the input
// register to the result register. The result register frees itself as soon
// as m_tready is high; input is taken while a result waits if the input
// register is empty. Limits must be written on the cfg port only while no
// item is in flight; the block does not enforce this. Both limits reset to 100.
module line_indent_tokenizer_top (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        s_tvalid,
	output logic            s_tready,
	input  var logic [7:0]  s_tdata,   // data_byte
	input  var logic        s_tuser,   // end_of_input
	output logic            m_tvalid,
	input  var logic        m_tready,
	// echo_byte, token_number, char_position, token_first, line_status,
	// tokens_in_line, indent_length, two zero bits
	output logic [47:0]     m_tdata,
	output logic [1:0]      m_tuser,   // byte_role
	output logic            m_tlast,   // line_done
	input  var logic        cfg_valid,
	output logic            cfg_ready,
	input  var logic        cfg_index,
	input  var logic [7:0]  cfg_data
);
	import lit_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;
	logic        valid_s2;
	lit_result_t res_s2;
	lit_state_t  state_q;
	lit_state_t  state_next;
	lit_result_t result;
	logic [7:0]  max_len_q;
	logic [7:0]  max_cnt_q;
	logic        advance_s2;
	logic        fire_s1;

	assign advance_s2 = !valid_s2 || m_tready;
	assign fire_s1    = valid_s1 && advance_s2;
	assign s_tready   = !valid_s1 || advance_s2;
	assign cfg_ready  = 1'b1;

	lit_step u_step (
		.state            (state_q),
		.data_byte        (byte_s1),
		.end_of_input     (eoi_s1),
		.max_token_length (max_len_q),
		.count_limit      (max_cnt_q),
		.state_next       (state_next),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			state_q   <= '0;
			max_len_q <= LIMIT_RESET;
			max_cnt_q <= LIMIT_RESET;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance_s2)
				valid_s2 <= valid_s1;
			if (fire_s1)
				state_q <= state_next;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAX_LENGTH)
					max_len_q <= cfg_data;
				else
					max_cnt_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tuser;
		end
		if (fire_s1)
			res_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.byte_role;
	assign m_tlast  = res_s2.line_done;
	assign m_tdata  = {2'b00, res_s2.indent_length, res_s2.tokens_in_line,
		res_s2.line_status, res_s2.token_first, res_s2.char_position,
		res_s2.token_number, res_s2.echo_byte};

endmodule
`default_nettype wire

@@ rtl/core/lit_checker.sv @@
// port-level checks for the line indent tokenizer, bound to the top level
`default_nettype none
module lit_checker (
	input var logic        clk,
	input var logic        arst_n,
	input var logic        m_tvalid,
	input var logic        m_tready,
	input var logic [47:0] m_tdata,
	input var logic [1:0]  m_tuser,
	input var logic        m_tlast
);
	import lit_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_line_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ROLE_LINE_END |-> m_tlast)
		else $error("line end without line_done");

	a_counts_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[27:25] == STATUS_OK
			&& m_tdata[36:28] == 9'd0 && m_tdata[45:37] == 9'd0)
		else $error("line summary set on an open line");

	a_first_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[24] |-> m_tuser == ROLE_TOKEN && m_tdata[23:16] == 8'd0)
		else $error("token start not at position zero of a token char");

endmodule

bind line_indent_tokenizer_top lit_checker u_lit_checker (.*);
`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the line indent tokenizer: random text lines checked against a local predictor
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lit_pkg::*;

	localparam int CycleLimit = 200000;

	typedef struct {
		logic [7:0] data;
		logic       eoi;
	} text_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_MAX_LENGTH;
	logic [7:0]  cfg_data = '0;

	text_item_t  send_q[$];
	lit_result_t want_q[$];

	// predictor state
	logic [1:0]  pmode = MODE_INDENT;
	logic [8:0]  indent_run = '0;
	logic [8:0]  token_run = '0;
	logic [8:0]  token_tally = '0;
	logic [7:0]  max_len = LIMIT_RESET;
	logic [7:0]  max_tokens = LIMIT_RESET;

	int cycles = 0;
	int issued = 0;
	int taken = 0;
	int results = 0;
	int errors = 0;
	int settings = 1;
	int lines_by_status[5] = '{default: 0};
	logic in_take = 1'b0;
	logic quiet = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_off = 0;
	logic hold_off_done = 1'b0;

	line_indent_tokenizer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic lit_result_t tokenize_byte(input logic [7:0] b, input logic eoi);
		lit_result_t r;
		logic done;
		logic [2:0] st;
		r = '0;
		done = 1'b0;
		st = STATUS_OK;
		r.echo_byte = eoi ? 8'd0 : b;
		if (eoi || b == CHAR_LF || b == CHAR_CR) begin
			r.byte_role = ROLE_LINE_END;
			done = 1'b1;
			if (pmode == MODE_TOKEN && token_run != 0) begin
				token_tally = token_tally + 9'd1;
				if (token_tally > max_tokens)
					st = STATUS_TOO_MANY;
			end
		end else if (b < CHAR_SPACE && b != CHAR_TAB) begin
			r.byte_role = ROLE_LINE_END;
			done = 1'b1;
			st = STATUS_CONTROL;
		end else if (b == CHAR_TAB || b == CHAR_SPACE) begin
			if (pmode == MODE_INDENT) begin
				r.byte_role = ROLE_INDENT;
				indent_run = indent_run + 9'd1;
				r.char_position = indent_run[7:0] - 8'd1;
				if (indent_run > max_len) begin
					done = 1'b1;
					st = STATUS_INDENT_LONG;
				end
			end else begin
				r.byte_role = ROLE_SEP;
				if (pmode == MODE_TOKEN) begin
					pmode = MODE_SKIP;
					token_run = '0;
					token_tally = token_tally + 9'd1;
					if (token_tally > max_tokens) begin
						done = 1'b1;
						st = STATUS_TOO_MANY;
					end
				end
			end
		end else begin
			if (pmode != MODE_TOKEN) begin
				pmode = MODE_TOKEN;
				token_run = '0;
				r.token_first = 1'b1;
			end
			token_run = token_run + 9'd1;
			r.byte_role = ROLE_TOKEN;
			r.token_number = token_tally[7:0];
			r.char_position = token_run[7:0] - 8'd1;
			if (token_run > max_len) begin
				done = 1'b1;
				st = STATUS_TOKEN_LONG;
			end
		end
		if (done) begin
			r.line_done = 1'b1;
			r.line_status = st;
			r.tokens_in_line = token_tally;
			r.indent_length = indent_run;
			pmode = MODE_INDENT;
			indent_run = '0;
			token_run = '0;
			token_tally = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (errors < 40)
			$display("result %0d: %s is %0d, expected %0d", results, field, got, want);
		errors++;
	endtask

	task automatic compare_field(input string field, input int got, input int want);
		if (got != want)
			report_mismatch(field, got, want);
	endtask

	// input side: one item per handshake, gaps only between items
	always @(negedge clk) begin
		logic keep;
		if (in_take)
			void'(send_q.pop_front());
		keep = s_tvalid && !in_take;
		if (keep) begin
		end else if (send_gap > 0) begin
			send_gap--;
			s_tvalid <= 1'b0;
		end else if (!quiet && send_q.size() > 0 && $urandom_range(0, 9) == 0) begin
			send_gap = $urandom_range(1, 3) - 1;
			s_tvalid <= 1'b0;
		end else if (send_q.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= send_q[0].data;
			s_tuser <= send_q[0].eoi;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// output side: short random stalls and one long hold-off
	always @(negedge clk) begin
		if (!hold_off_done && results >= 150) begin
			hold_off_done = 1'b1;
			hold_off = 60;
		end
		if (hold_off > 0) begin
			hold_off--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 3) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	always @(posedge clk) begin
		lit_result_t got, want;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, want_q.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			in_take <= arst_n && s_tvalid && s_tready;
			if (arst_n && m_tvalid && m_tready) begin
				got.echo_byte = m_tdata[7:0];
				got.token_number = m_tdata[15:8];
				got.char_position = m_tdata[23:16];
				got.token_first = m_tdata[24];
				got.line_status = m_tdata[27:25];
				got.tokens_in_line = m_tdata[36:28];
				got.indent_length = m_tdata[45:37];
				got.byte_role = m_tuser;
				got.line_done = m_tlast;
				if (want_q.size() == 0) begin
					report_mismatch("unexpected result, byte", int'(got.echo_byte), -1);
				end else begin
					want = want_q.pop_front();
					compare_field("echo_byte", int'(got.echo_byte), int'(want.echo_byte));
					compare_field("byte_role", int'(got.byte_role), int'(want.byte_role));
					compare_field("token_number", int'(got.token_number),
						int'(want.token_number));
					compare_field("char_position", int'(got.char_position),
						int'(want.char_position));
					compare_field("token_first", int'(got.token_first),
						int'(want.token_first));
					compare_field("line_done", int'(got.line_done), int'(want.line_done));
					compare_field("line_status", int'(got.line_status),
						int'(want.line_status));
					compare_field("tokens_in_line", int'(got.tokens_in_line),
						int'(want.tokens_in_line));
					compare_field("indent_length", int'(got.indent_length),
						int'(want.indent_length));
					compare_field("pad bits", int'(m_tdata[47:46]), 0);
				end
				results++;
			end
			if (arst_n && cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_LENGTH: max_len = cfg_data;
					CFG_MAX_COUNT: max_tokens = cfg_data;
					default: ;
				endcase
			end
			if (arst_n && s_tvalid && s_tready) begin
				want = tokenize_byte(s_tdata, s_tuser);
				if (want.line_done)
					lines_by_status[want.line_status]++;
				want_q.insert(want_q.size(), want);
				taken++;
			end
		end
	end

	task automatic add_item(input logic [7:0] d, input logic e = 1'b0);
		text_item_t entry;
		entry.data = d;
		entry.eoi = e;
		send_q.insert(send_q.size(), entry);
		issued++;
	endtask

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? CHAR_TAB : CHAR_SPACE;
	endfunction

	function automatic logic [7:0] control_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 31));
		while (c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR);
		return c;
	endfunction

	// mostly short, sometimes right at or just past the limit
	function automatic int pick_len(input int lim, input int lo);
		if (lim <= 16 && $urandom_range(0, 5) == 0)
			return lim + $urandom_range(0, 1);
		return $urandom_range(lo, lim < 4 ? lim : 4);
	endfunction

	task automatic add_random_line(input int lim_len, input int lim_cnt);
		int n_tok, tlen, pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4))
				add_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
		end else begin
			repeat (pick_len(lim_len, 0))
				add_item(blank_char());
			n_tok = pick_len(lim_cnt, 0);
			for (int k = 0; k < n_tok; k++) begin
				tlen = pick_len(lim_len, 1);
				repeat (tlen)
					add_item(8'($urandom_range(33, 255)));
				if (k < n_tok - 1 || $urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2))
						add_item(blank_char());
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				add_item(CHAR_LF);
			else if (pick < 65)
				add_item(CHAR_CR);
			else if (pick < 80)
				add_item(8'($urandom_range(0, 255)), 1'b1);
			else if (pick < 92)
				add_item(control_char());
		end
	endtask

	task automatic random_lines(input int lim_len, input int lim_cnt, input int count);
		int start;
		@(posedge clk);
		start = issued;
		while (issued - start < count)
			add_random_line(lim_len, lim_cnt);
	endtask

	task automatic drain();
		while (taken != issued || results != issued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_limits(input logic [7:0] len, input logic [7:0] cnt);
		set_limit(CFG_MAX_LENGTH, len);
		set_limit(CFG_MAX_COUNT, cnt);
		settings++;
	endtask

	// default limits: roles, positions, all line ends, control chars
	task automatic directed_basic();
		@(posedge clk);
		add_item(CHAR_TAB);
		add_item(CHAR_SPACE);
		add_item(8'hFF);
		add_item(8'h21);
		add_item(CHAR_SPACE);
		add_item(CHAR_TAB);
		add_item(8'h80);
		add_item(CHAR_CR);
		add_item(8'hA5, 1'b1);
		add_item(8'h00);
		add_item(8'h78);
		add_item(8'h1F);
		add_item(8'h7F);
		add_item(CHAR_LF);
		add_item(CHAR_SPACE);
		add_item(CHAR_LF);
		add_item(8'h61);
		add_item(CHAR_SPACE);
		add_item(8'h5A, 1'b1);
	endtask

	// limits of one: over-long indent and token, too many tokens at a blank and at line end
	task automatic directed_limits();
		@(posedge clk);
		add_item(8'h61);
		add_item(8'h62);
		add_item(CHAR_SPACE);
		add_item(CHAR_TAB);
		add_item(8'h61);
		add_item(CHAR_SPACE);
		add_item(8'h62);
		add_item(CHAR_SPACE);
		add_item(8'h61);
		add_item(CHAR_TAB);
		add_item(8'h62);
		add_item(CHAR_LF);
		add_item(CHAR_SPACE);
		add_item(8'h63);
		add_item(8'h0B);
	endtask

	// full-width counts with limits of 255
	task automatic long_lines();
		@(posedge clk);
		repeat (256)
			add_item(blank_char());
		repeat (256)
			add_item(8'($urandom_range(33, 255)));
		repeat (256) begin
			add_item(8'($urandom_range(33, 255)));
			add_item(blank_char());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_basic();
		drain();
		load_limits(8'd1, 8'd1);
		directed_limits();
		random_lines(1, 1, 150);
		drain();
		load_limits(8'd255, 8'd255);
		long_lines();
		random_lines(255, 255, 60);
		drain();
		load_limits(8'd3, 8'd2);
		random_lines(3, 2, 200);
		drain();
		load_limits(8'd255, 8'd1);
		random_lines(255, 1, 120);
		drain();
		load_limits(8'd1, 8'd255);
		random_lines(1, 255, 120);
		drain();
		begin
			logic [7:0] len, cnt;
			len = 8'($urandom_range(1, 8));
			cnt = 8'($urandom_range(1, 8));
			load_limits(len, cnt);
			random_lines(int'(len), int'(cnt), 150);
			drain();
			quiet = 1'b1;
			len = 8'($urandom_range(2, 12));
			cnt = 8'($urandom_range(2, 12));
			load_limits(len, cnt);
			random_lines(int'(len), int'(cnt), 150);
			drain();
		end
		$display("run covered %0d bytes under %0d limit settings, with a long output hold-off",
			issued, settings);
		$display("lines ended: ok %0d, control %0d, indent long %0d, token long %0d, too many %0d",
			lines_by_status[STATUS_OK], lines_by_status[STATUS_CONTROL],
			lines_by_status[STATUS_INDENT_LONG], lines_by_status[STATUS_TOKEN_LONG],
			lines_by_status[STATUS_TOO_MANY]);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
